@@ design/mmt_pkg.sv @@
// Shared types and constants for the matrix multiply engine.
// No dependencies; imported by every module of the block.
package mmt_pkg;

  localparam int MAX_DIM_DEF   = 16;
  localparam int ELEM_BITS_DEF = 16;
  localparam int SUM_W         = 36;
  localparam int IDX_W         = 4;
  localparam int VAL_W         = 16;
  localparam int SIZE_W        = 5;
  localparam int CFG_ADDR_W    = 2;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 48;

  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TRANSPOSE_A = 2'd0,
    CFG_TRANSPOSE_B = 2'd1,
    CFG_SIZE        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

@@ design/mmt_mac.sv @@
// Shared multiply-accumulate unit: registered product, then exact accumulate.
// Depends on mmt_pkg.
module mmt_mac import mmt_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mac_ctrl_t                   ctrl_i,
  input  logic signed [ELEM_BITS-1:0] a_i,
  input  logic signed [ELEM_BITS-1:0] b_i,
  output logic                        busy_o,
  output logic        [SUM_W-1:0]     acc_o
);

  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [EXT_W-1:0]  prod_ext;
  logic                     mul_v_q;
  logic        [SUM_W-1:0]  acc_q;

  assign prod_ext = EXT_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      mul_v_q <= ctrl_i.en;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (mul_v_q) begin
        acc_q <= acc_q + prod_ext[SUM_W-1:0];
      end
    end
  end

  assign busy_o = mul_v_q;
  assign acc_o  = acc_q;

endmodule

@@ design/matrix_multiply_transpose_modes.sv @@
// Read item: RUN steps k over the active size n, then DRAIN and FIN; no new item is taken
// until IDLE. The result is registered in FIN; out-of-range reads go straight to FIN.
// A stalled result holds the next read in FIN, and the input with it, until it is taken.
// The one multiply-accumulate unit takes one product per cycle in RUN; loads write the store on transfer.
// Reset clears control and registers (size 16, no transpose); stores are not cleared.
// Depends on mmt_pkg and mmt_mac.
module matrix_multiply_transpose_modes import mmt_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
  input  logic [1:0]            s_axis_tuser,  // func[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // sum[35:0], out_row[39:36],
                                               // out_col[43:40], zero[47:44]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [SIZE_W-1:0]     cfg_data_i
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic              ta_q, tb_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] n_eff;
  logic [SIZE_W-1:0] k_q, k_d;
  logic [IDX_W-1:0]  row_q, col_q;
  logic              rd_v_q;
  logic              issue;
  logic              accept;

  logic [IDX_W-1:0]  in_row, in_col;
  logic [VAL_W-1:0]  in_val;
  logic [31:0]       val_ext;
  func_e             in_func;
  logic              in_range;
  logic [31:0]       wr_addr_full, a_addr_full, b_addr_full;
  logic [AW-1:0]     wr_addr, a_addr, b_addr;
  logic              wr_a, wr_b;

  logic [ELEM_BITS-1:0] a_mem [DEPTH];
  logic [ELEM_BITS-1:0] b_mem [DEPTH];
  logic [ELEM_BITS-1:0] a_rd_q, b_rd_q;

  mac_ctrl_t         mac_ctrl;
  logic              mac_busy;
  logic [SUM_W-1:0]  acc;

  logic              out_valid_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic [IDX_W-1:0]  out_row_q, out_col_q;
  logic              out_load;

  assign in_row  = s_axis_tdata[3:0];
  assign in_col  = s_axis_tdata[7:4];
  assign in_val  = s_axis_tdata[23:8];
  assign in_func = func_e'(s_axis_tuser);
  assign val_ext = {{(32 - VAL_W){in_val[VAL_W-1]}}, in_val};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign n_eff = (32'(size_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_q   <= 1'b0;
      tb_q   <= 1'b0;
      size_q <= SIZE_W'(16);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TRANSPOSE_A: ta_q   <= cfg_data_i[0];
        CFG_TRANSPOSE_B: tb_q   <= cfg_data_i[0];
        CFG_SIZE:        size_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // store writes
  assign in_range     = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign wr_addr_full = 32'(in_row) * MAX_DIM + 32'(in_col);
  assign wr_addr      = wr_addr_full[AW-1:0];
  assign wr_a         = accept && in_range && (in_func == FUNC_LOAD_A);
  assign wr_b         = accept && in_range && (in_func == FUNC_LOAD_B);

  // read addresses for step k
  assign a_addr_full = ta_q ? (32'(k_q) * MAX_DIM + 32'(row_q))
                            : (32'(row_q) * MAX_DIM + 32'(k_q));
  assign b_addr_full = tb_q ? (32'(col_q) * MAX_DIM + 32'(k_q))
                            : (32'(k_q) * MAX_DIM + 32'(col_q));
  assign a_addr      = a_addr_full[AW-1:0];
  assign b_addr      = b_addr_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_mem[wr_addr] <= val_ext[ELEM_BITS-1:0];
    end
    a_rd_q <= a_mem[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      b_mem[wr_addr] <= val_ext[ELEM_BITS-1:0];
    end
    b_rd_q <= b_mem[b_addr];
  end

  // sequencer
  assign issue    = (state_q == ST_RUN);
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_READ)) begin
          k_d = '0;
          if (({1'b0, in_row} < n_eff) && ({1'b0, in_col} < n_eff)) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        k_d = k_q + SIZE_W'(1);
        if (k_q == n_eff - SIZE_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !mac_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      rd_v_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= in_row;
      col_q <= in_col;
    end
  end

  assign mac_ctrl.clear = accept;
  assign mac_ctrl.en    = rd_v_q;

  mmt_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q <= acc;
      out_row_q <= row_q;
      out_col_q <= col_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - SUM_W - 2 * IDX_W){1'b0}},
                          out_col_q, out_row_q, out_sum_q};

endmodule

@@ design/mmt_checker.sv @@
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mmt_pkg and matrix_multiply_transpose_modes.
module mmt_checker import mmt_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [1:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_xfer;
  logic is_read;

  assign s_xfer  = s_axis_tvalid && s_axis_tready;
  assign is_read = (s_axis_tuser == FUNC_READ);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && is_read |=> !s_axis_tready)
    else $error("ready after a read transfer");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && !is_read && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result from a non-read item");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

  a_echo_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:SUM_W+2*IDX_W] == '0))
    else $error("padding bits not zero");

endmodule

bind matrix_multiply_transpose_modes mmt_checker u_mmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
